// File: design/assert_macros.svh
// Assertion helpers included by the segment table design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is applied.
`define CACK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that holds during reset as well.
`define CACK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/cack_pkg.sv
// ----------------------------------------------------------------------------
// cack_pkg
// Shared constants and types for the cumulative acknowledgment segment table.
// ----------------------------------------------------------------------------
package cack_pkg;

	localparam int SEG_SLOTS = 16;
	localparam int CNT_W     = $clog2(SEG_SLOTS + 1);
	localparam int RND_W     = $clog2(SEG_SLOTS);

	localparam logic [1:0] OP_APPEND  = 2'd0;
	localparam logic [1:0] OP_QUERY   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Priority chain that runs from the oldest cell to the newest one.
	typedef struct packed {
		logic        hit;
		logic [15:0] len;
	} chain_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

endpackage

// File: design/cack_cell.sv
// ----------------------------------------------------------------------------
// cack_cell
// One record of the segment table with its sequence compare and priority link.
// ----------------------------------------------------------------------------
module cack_cell import cack_pkg::*; (
	input  logic        clk,
	input  logic        load,
	input  logic        shift,
	input  logic [31:0] wr_seq,
	input  logic [15:0] wr_len,
	input  logic [31:0] nbr_seq,
	input  logic [15:0] nbr_len,
	input  logic        live,
	input  logic [31:0] ack,
	input  chain_t      chain_in,
	output logic [31:0] rec_seq,
	output logic [15:0] rec_len,
	output chain_t      chain_out
);

	logic [31:0] record_seq_q;
	logic [15:0] record_len_q;

	// A release moves the younger neighbor's record down one place.
	always_ff @(posedge clk) begin
		if (shift) begin
			record_seq_q <= nbr_seq;
			record_len_q <= nbr_len;
		end else if (load) begin
			record_seq_q <= wr_seq;
			record_len_q <= wr_len;
		end
	end

	assign rec_seq = record_seq_q;
	assign rec_len = record_len_q;

	// An older match already on the chain takes precedence.
	always_comb begin
		chain_out.hit = chain_in.hit | (live & (record_seq_q == ack));
		chain_out.len = chain_in.hit ? chain_in.len : record_len_q;
	end

endmodule

// File: design/cumulative_ack_from_segment_table.sv
// ----------------------------------------------------------------------------
// cumulative_ack_from_segment_table
// Segment record queue with a cumulative acknowledgment search.
// ----------------------------------------------------------------------------
// Append and release words have their result registered the cycle after
// acceptance. A query moves the acknowledgment point one advance per cycle
// through the compare chain of the record cells, and its search stops at the
// first round without an advance. At the bound of SEG_SLOTS advances no closing
// compare round is needed. One word is in work at a time. Reset (arst_n low)
// empties the table and drops any pending result word.
module cumulative_ack_from_segment_table import cack_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] seg_seq,
	input  logic [15:0] seg_len,
	input  logic [31:0] start_ack,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] ack_value,
	output logic [1:0]  status,
	output logic [4:0]  entries_in_use
);

`include "assert_macros.svh"

	// The table is kept as a queue of cells ordered by age: cell 0 holds the
	// oldest live record and cell count_q-1 the newest. An append writes cell
	// count_q, and a release shifts every cell one place toward cell 0, so
	// the ring indices of the original scheme reduce to a single fill count.
	logic [CNT_W-1:0] count_q;
	state_t           state_q, state_d;
	logic [31:0]      scan_ack_q;
	logic [RND_W-1:0] round_q;

	logic             out_valid_q;
	logic [31:0]      ack_value_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] entries_q;

	logic             in_take;
	logic             out_take;
	logic             do_append;
	logic             do_release;
	logic             full;
	logic             empty;
	logic             advance;
	logic             scan_done;
	logic [31:0]      ack_next;

	logic [31:0] cell_seq [SEG_SLOTS];
	logic [15:0] cell_len [SEG_SLOTS];
	chain_t      chain    [SEG_SLOTS+1];

	// A new word waits while a query is being searched or while the result
	// register is still full and not being drained in this cycle.
	assign in_stall = (state_q != S_IDLE) | (out_valid_q & out_stall);
	assign in_take  = in_valid & ~in_stall;
	assign out_take = out_valid_q & ~out_stall;

	assign full       = (count_q == CNT_W'(SEG_SLOTS));
	assign empty      = (count_q == '0);
	assign do_append  = in_take & (op == OP_APPEND) & ~full;
	assign do_release = in_take & (op == OP_RELEASE) & ~empty;

	// The chain enters at the oldest cell with no match.
	assign chain[0] = '0;

	for (genvar i = 0; i < SEG_SLOTS; i++) begin : g_cell
		logic [31:0] nbr_seq;
		logic [15:0] nbr_len;

		// The youngest cell has no neighbor; its content is stale after a
		// release and is never read as live.
		if (i == SEG_SLOTS - 1) begin : g_last
			assign nbr_seq = cell_seq[i];
			assign nbr_len = cell_len[i];
		end else begin : g_mid
			assign nbr_seq = cell_seq[i+1];
			assign nbr_len = cell_len[i+1];
		end

		cack_cell u_cell (
			.clk       (clk),
			.load      (do_append & (count_q == CNT_W'(i))),
			.shift     (do_release),
			.wr_seq    (seg_seq),
			.wr_len    (seg_len),
			.nbr_seq   (nbr_seq),
			.nbr_len   (nbr_len),
			.live      (CNT_W'(i) < count_q),
			.ack       (scan_ack_q),
			.chain_in  (chain[i]),
			.rec_seq   (cell_seq[i]),
			.rec_len   (cell_len[i]),
			.chain_out (chain[i+1])
		);
	end

	// One search round per cycle: the oldest matching record wins. A match
	// of zero length cannot move the point, so it ends the search as if
	// nothing matched. The search also ends after SEG_SLOTS advances.
	assign advance   = chain[SEG_SLOTS].hit & (chain[SEG_SLOTS].len != '0);
	assign ack_next  = scan_ack_q + 32'(chain[SEG_SLOTS].len);
	assign scan_done = (state_q == S_SCAN) &
		(~advance | (round_q == RND_W'(SEG_SLOTS - 1)));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take && op == OP_QUERY) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Fill count of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_append) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_release) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Search point and round counter.
	always_ff @(posedge clk) begin
		if (in_take && op == OP_QUERY) begin
			scan_ack_q <= start_ack;
			round_q    <= '0;
		end else if (state_q == S_SCAN && advance) begin
			scan_ack_q <= ack_next;
			round_q    <= round_q + RND_W'(1);
		end
	end

	// Result register. Append, release and unused codes report at once;
	// a query reports when its search ends. During a search the register
	// is known to be empty, since the query was only taken when it drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_take && op != OP_QUERY) || scan_done) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done) begin
			ack_value_q <= advance ? ack_next : scan_ack_q;
			status_q    <= ST_OK;
			entries_q   <= count_q;
		end else if (in_take && op != OP_QUERY) begin
			ack_value_q <= '0;
			entries_q   <= count_q;
			status_q    <= ST_OK;
			priority if (op == OP_APPEND) begin
				if (full) begin
					status_q <= ST_FULL;
				end else begin
					entries_q <= count_q + CNT_W'(1);
				end
			end else if (op == OP_RELEASE) begin
				if (empty) begin
					status_q <= ST_EMPTY;
				end else begin
					entries_q <= count_q - CNT_W'(1);
				end
			end else begin
				// The unused code changes nothing and reports ok.
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign ack_value      = ack_value_q;
	assign status         = status_q;
	assign entries_in_use = 5'(entries_q);

	// The fill count never passes the table depth.
	`CACK_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(SEG_SLOTS), "fill count overflow")

	// A search runs only while the result register is empty.
	`CACK_ASSERT(a_scan_out_empty, clk, arst_n, (state_q == S_SCAN) |-> !out_valid_q,
		"result pending during search")

	// An accepted query always starts a search.
	`CACK_ASSERT(a_query_scan, clk, arst_n,
		(in_take && op == OP_QUERY) |=> (state_q == S_SCAN), "query did not start a search")

	// An accepted append into a table with room grows the count by one.
	`CACK_ASSERT(a_append_count, clk, arst_n,
		do_append |=> (count_q == $past(count_q) + CNT_W'(1)), "append did not grow the table")

endmodule

// File: tb/cumulative_ack_from_segment_table_tb.sv
// ----------------------------------------------------------------------------
// cumulative_ack_from_segment_table_tb
// Checks the segment record table and its cumulative acknowledgment search
// against an in-bench table model. Each accepted word is applied to the model
// and its result is queued. Every result the block hands out is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cumulative_ack_from_segment_table_tb;
	import cack_pkg::*;

	// The op field has four codes, and the block must ignore the one it does not use.
	localparam logic [1:0] OP_SPARE = 2'd3;

	// This margin covers the longest query search and any word still in work.
	localparam int SETTLE_CYCLES = 2 * SEG_SLOTS + 8;
	localparam int HOLD_CYCLES   = 160;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [31:0] ack;
		logic [1:0]  st;
		logic [4:0]  used;
	} seg_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [31:0] seg_seq;
	logic [15:0] seg_len;
	logic [31:0] start_ack;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] ack_value;
	logic [1:0]  status;
	logic [4:0]  entries_in_use;

	// This is the bench's own copy of the ring. Positions count modulo 2*SEG_SLOTS,
	// so a full table and an empty table can be told apart.
	logic [31:0] tbl_seq [SEG_SLOTS];
	logic [15:0] tbl_len [SEG_SLOTS];
	int unsigned oldest_pos = 0;
	int unsigned newest_pos = 0;

	seg_result_t results_due[$];

	// The stimulus writes contiguous records from this sequence point.
	logic [31:0] stream_next;

	// When steady_flow is set, neither side idles. When hold_req is set, the
	// receiver stalls for a long stretch.
	bit steady_flow = 1'b0;
	bit hold_req    = 1'b0;

	int mismatches      = 0;
	int words_sent      = 0;
	int results_checked = 0;
	int queries_moved   = 0;
	int full_appends    = 0;
	int empty_releases  = 0;
	int cycle_count     = 0;

	cumulative_ack_from_segment_table i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.seg_seq        (seg_seq),
		.seg_len        (seg_len),
		.start_ack      (start_ack),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ack_value      (ack_value),
		.status         (status),
		.entries_in_use (entries_in_use)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Table model
	// --------------------------------------------------------------------

	function automatic int live_records();
		return (newest_pos + 2 * SEG_SLOTS - oldest_pos) % (2 * SEG_SLOTS);
	endfunction

	// This returns the start sequence of the k-th live record, where 0 is the oldest.
	function automatic logic [31:0] live_record_seq(input int k);
		return tbl_seq[((oldest_pos + k) % (2 * SEG_SLOTS)) % SEG_SLOTS];
	endfunction

	// The search walks the live records from oldest to newest. The first record whose
	// start equals the running ack decides the step. A zero-length record ends the
	// search, because the ack cannot move past it. There are never more than SEG_SLOTS steps.
	function automatic logic [31:0] advance_ack(input logic [31:0] from_ack);
		logic [31:0] a;
		int          n;
		int          rnd;
		int          k;
		int          slot;
		bit          moved;
		a = from_ack;
		n = live_records();
		for (rnd = 0; rnd < SEG_SLOTS; rnd++) begin
			moved = 1'b0;
			for (k = 0; k < n; k++) begin
				slot = ((oldest_pos + k) % (2 * SEG_SLOTS)) % SEG_SLOTS;
				if (tbl_seq[slot] == a) begin
					if (tbl_len[slot] != 16'd0) begin
						a = a + {16'd0, tbl_len[slot]};
						moved = 1'b1;
					end
					break;
				end
			end
			if (!moved)
				break;
		end
		return a;
	endfunction

	function automatic seg_result_t seg_table_step(input logic [1:0] w_op,
			input logic [31:0] w_seq, input logic [15:0] w_len, input logic [31:0] w_start);
		seg_result_t r;
		int          slot;
		int          n;
		r.ack = 32'd0;
		r.st  = ST_OK;
		case (w_op)
			OP_APPEND: begin
				if (live_records() >= SEG_SLOTS) begin
					r.st = ST_FULL;
				end else begin
					slot = newest_pos % SEG_SLOTS;
					tbl_seq[slot] = w_seq;
					tbl_len[slot] = w_len;
					newest_pos = (newest_pos + 1) % (2 * SEG_SLOTS);
				end
			end
			OP_QUERY: begin
				r.ack = advance_ack(w_start);
			end
			OP_RELEASE: begin
				if (live_records() == 0)
					r.st = ST_EMPTY;
				else
					oldest_pos = (oldest_pos + 1) % (2 * SEG_SLOTS);
			end
			default: begin
			end
		endcase
		n = live_records();
		r.used = n[4:0];
		return r;
	endfunction

	// --------------------------------------------------------------------
	// Sender side
	// --------------------------------------------------------------------

	function automatic logic [15:0] pick_len(input int lo, input int hi);
		logic [31:0] t;
		t = $urandom_range(hi, lo);
		return t[15:0];
	endfunction

	// This task offers one word and holds it until the block takes it. The model is
	// updated at acceptance, so the queue stays in block order. Valid is lowered
	// only when a gap follows. When the next word comes straight after, valid stays high.
	task automatic send_word(input logic [1:0] w_op, input logic [31:0] w_seq,
			input logic [15:0] w_len, input logic [31:0] w_start);
		seg_result_t r;
		in_valid  <= 1'b1;
		op        <= w_op;
		seg_seq   <= w_seq;
		seg_len   <= w_len;
		start_ack <= w_start;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = seg_table_step(w_op, w_seq, w_len, w_start);
		results_due.push_back(r);
		words_sent++;
		if (w_op == OP_APPEND && r.st == ST_FULL)
			full_appends++;
		if (w_op == OP_RELEASE && r.st == ST_EMPTY)
			empty_releases++;
		if (w_op == OP_QUERY && r.ack != w_start)
			queries_moved++;
		if (!steady_flow && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	// The sender stops here until every queued result has come back. It then waits out
	// the settle margin, so a stray extra result would also show up.
	task automatic await_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// --------------------------------------------------------------------
	// Receiver side and result check
	// --------------------------------------------------------------------

	// Unless steady_flow is set, the receiver stalls at random, with a chance of 8 in a hundred.
	// When hold_req is set, it instead stalls until the hold counter here runs out, and then clears the flag.
	initial begin : receiver
		int held;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				out_stall <= !steady_flow && ($urandom_range(0, 99) < 8);
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s expected %h got %h",
				cycle_count, what, want, got);
	endtask

	// Outputs are read at the clock edge, before the block's own updates for that edge
	// take effect. This check sees the same values the block saw when it handed the word over.
	always @(posedge clk) begin : check_results
		seg_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with nothing pending, ack_value", 32'd0, ack_value);
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (ack_value !== want.ack)
					report_mismatch("ack_value", want.ack, ack_value);
				if (status !== want.st)
					report_mismatch("status", {30'd0, want.st}, {30'd0, status});
				if (entries_in_use !== want.used)
					report_mismatch("entries_in_use", {27'd0, want.used},
						{27'd0, entries_in_use});
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, results_due.size());
			$display("cumulative_ack_from_segment_table_tb: done, errors");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------

	// These words hit an empty table: a release with nothing to drop, queries at both ends
	// of the sequence space that must return their own start, and the unused op code.
	task automatic test_empty_table();
		send_word(OP_RELEASE, $urandom, pick_len(0, 65535), $urandom);
		send_word(OP_QUERY, $urandom, pick_len(0, 65535), 32'h0000_0000);
		send_word(OP_QUERY, $urandom, pick_len(0, 65535), 32'hFFFF_FFFF);
		send_word(OP_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	// This test fills the table with sixteen contiguous records that run across the
	// 32-bit wrap, with the longest and the shortest length among them. It then appends
	// once more to the full table and queries from the first start. The query has to make
	// all sixteen advances.
	task automatic test_full_chain();
		logic [31:0] s;
		logic [31:0] first;
		logic [15:0] l;
		int          i;
		s = 32'hFFFF_8000;
		first = s;
		for (i = 0; i < SEG_SLOTS; i++) begin
			if (i == 0)
				l = 16'hFFFF;
			else if (i == 1)
				l = 16'd1;
			else
				l = pick_len(1, 4000);
			send_word(OP_APPEND, s, l, $urandom);
			s = s + {16'd0, l};
		end
		stream_next = s;
		send_word(OP_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
		send_word(OP_QUERY, 32'h0000_0000, 16'h0000, first);
	endtask

	// Two records are dropped. A zero-length record is then placed at the end of the
	// chain, so the search stops there. A second record reuses a live start with another
	// length; the older record of the two must win.
	task automatic test_zero_len_and_duplicate();
		logic [31:0] dup_seq;
		send_word(OP_RELEASE, $urandom, pick_len(0, 65535), $urandom);
		send_word(OP_RELEASE, $urandom, pick_len(0, 65535), $urandom);
		send_word(OP_APPEND, stream_next, 16'd0, $urandom);
		dup_seq = live_record_seq(3);
		send_word(OP_APPEND, dup_seq, 16'd7, $urandom);
		send_word(OP_QUERY, $urandom, pick_len(0, 65535), live_record_seq(0));
		send_word(OP_QUERY, $urandom, pick_len(0, 65535), dup_seq);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering words.
	// The result register fills up and the block has to stall its input until the hold ends.
	task automatic test_receiver_hold();
		int i;
		logic [15:0] l;
		hold_req = 1'b1;
		for (i = 0; i < 24; i++) begin
			if (i % 4 == 3) begin
				send_word(OP_QUERY, $urandom, pick_len(0, 65535),
					(live_records() > 0) ? live_record_seq(0) : stream_next);
			end else if (i % 4 == 2) begin
				send_word(OP_RELEASE, $urandom, pick_len(0, 65535), $urandom);
			end else begin
				l = pick_len(1, 1500);
				send_word(OP_APPEND, stream_next, l, $urandom);
				if (live_records() < SEG_SLOTS)
					stream_next = stream_next + {16'd0, l};
			end
		end
	endtask

	// Most appends extend a contiguous stream, so queries follow long chains. The rest
	// are records ahead of the stream, zero-length records, reused starts and fully random
	// values. The traffic alternates between filling and draining the table, so it reaches
	// both a full and an empty table many times. Fields that an op ignores carry random values.
	task automatic test_random_traffic(input int count);
		int          i;
		int          pick;
		int          live;
		int          k;
		bit          filling;
		logic [1:0]  w_op;
		logic [31:0] w_seq;
		logic [31:0] w_start;
		logic [15:0] w_len;
		filling = 1'b1;
		for (i = 0; i < count; i++) begin
			steady_flow = (i >= count / 3) && (i < count / 3 + 150);
			live = live_records();
			if ((live == SEG_SLOTS || live == 0) && $urandom_range(0, 99) < 30)
				filling = (live == 0);
			w_seq   = $urandom;
			w_len   = pick_len(0, 65535);
			w_start = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				w_op = OP_SPARE;
			else if (pick < 33)
				w_op = OP_QUERY;
			else if (pick < (filling ? 83 : 48))
				w_op = OP_APPEND;
			else
				w_op = OP_RELEASE;

			if (w_op == OP_APPEND) begin
				// On an empty table, the stream sometimes jumps. Often it lands just below the wrap.
				if (live == 0 && $urandom_range(0, 4) == 0)
					stream_next = $urandom_range(0, 1) ? {16'hFFFF, pick_len(0, 65535)}
						: $urandom;
				k = $urandom_range(0, 19);
				if (k == 2) begin
					w_seq = stream_next + $urandom_range(1, 1500);
					w_len = pick_len(1, 1500);
				end else if (k == 3) begin
					w_seq = stream_next;
					w_len = 16'd0;
				end else if ((k == 4 || k == 5) && live > 0) begin
					w_seq = live_record_seq($urandom_range(0, live - 1));
					w_len = pick_len(1, 1500);
				end else if (k > 5) begin
					w_seq = stream_next;
					w_len = ($urandom_range(0, 19) == 0) ? 16'hFFFF : pick_len(1, 1500);
					if (live < SEG_SLOTS)
						stream_next = stream_next + {16'd0, w_len};
				end
			end else if (w_op == OP_QUERY) begin
				k = $urandom_range(0, 99);
				if (live > 0 && k < 60)
					w_start = live_record_seq($urandom_range(0, live - 1));
				else if (k < 80)
					w_start = stream_next;
			end
			send_word(w_op, w_seq, w_len, w_start);
		end
		steady_flow = 1'b0;
	endtask

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_APPEND;
		seg_seq     = 32'd0;
		seg_len     = 16'd0;
		start_ack   = 32'd0;
		stream_next = $urandom;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_full_chain();
		test_zero_len_and_duplicate();
		// The sender pauses here until the table has answered everything so far.
		await_results();
		test_receiver_hold();
		await_results();
		test_random_traffic(700);
		await_results();

		$display("sent %0d words and checked %0d results; %0d queries moved the ack",
			words_sent, results_checked, queries_moved);
		$display("appends to a full table: %0d, releases on an empty table: %0d",
			full_appends, empty_releases);
		if (mismatches == 0) begin
			$display("cumulative_ack_from_segment_table_tb: done, clean");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("cumulative_ack_from_segment_table_tb: done, errors");
		end
		$finish;
	end

endmodule
